### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/rtiq_pkg.sv
// Types, coefficients and helper functions of the RGB quad to I420 converter.
// No dependencies; used by the interfaces, the datapath modules and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rtiq_pkg;

  // One 2x2 quad of RGB pixels: top-left, top-right, bottom-left, bottom-right
  typedef struct packed {
    logic [7:0] red_0;
    logic [7:0] green_0;
    logic [7:0] blue_0;
    logic [7:0] red_1;
    logic [7:0] green_1;
    logic [7:0] blue_1;
    logic [7:0] red_2;
    logic [7:0] green_2;
    logic [7:0] blue_2;
    logic [7:0] red_3;
    logic [7:0] green_3;
    logic [7:0] blue_3;
  } quad_t;

  // Four luma samples and one chroma pair
  typedef struct packed {
    logic [7:0] luma_0;
    logic [7:0] luma_1;
    logic [7:0] luma_2;
    logic [7:0] luma_3;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuv_t;

  // Luma weights
  localparam logic [7:0] LUMA_COEF_R = 8'd66;
  localparam logic [7:0] LUMA_COEF_G = 8'd129;
  localparam logic [7:0] LUMA_COEF_B = 8'd25;

  // Chroma weight magnitudes; the sign is given by the add or subtract
  localparam logic [7:0] CB_COEF_R = 8'd38;   // negative
  localparam logic [7:0] CB_COEF_G = 8'd74;   // negative
  localparam logic [7:0] CB_COEF_B = 8'd112;  // positive
  localparam logic [7:0] CR_COEF_R = 8'd112;  // positive
  localparam logic [7:0] CR_COEF_G = 8'd94;   // negative
  localparam logic [7:0] CR_COEF_B = 8'd18;   // negative

  // Rounding, offsets and ranges
  localparam logic [7:0]  ROUND_HALF    = 8'd128;
  localparam logic [16:0] CHROMA_BIAS   = 17'd32768;  // 128 << 8, keeps sum positive
  localparam logic [7:0]  LUMA_OFFSET   = 8'd16;
  localparam logic [7:0]  LUMA_MIN      = 8'd16;
  localparam logic [7:0]  LUMA_MAX      = 8'd235;
  localparam logic [7:0]  CHROMA_MIN    = 8'd16;
  localparam logic [7:0]  CHROMA_MAX    = 8'd240;

  // Clamp a small non-negative value into lo..hi
  function automatic logic [7:0] clamp_u8(input logic [9:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
    logic [7:0] res;
    if (v < {2'b00, lo}) begin
      res = lo;
    end else if (v > {2'b00, hi}) begin
      res = hi;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rtiq_quad_if.sv
// Input channel: valid/ready handshake carrying one RGB quad per item.
// Depends on rtiq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rtiq_quad_if import rtiq_pkg::*; ();
  logic  valid;
  logic  ready;
  quad_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rtiq_yuv_if.sv
// Output channel: valid/ready handshake carrying four luma and one chroma pair.
// Depends on rtiq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rtiq_yuv_if import rtiq_pkg::*; ();
  logic valid;
  logic ready;
  yuv_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rgb_to_i420_quad_converter.sv
// RGB quad to I420 converter, top level.
// An item offered at the input passes the input register, then the result register, to the output.
// Throughput: one quad per cycle unless the sink stalls; an empty input register still takes
// an item while a result waits. Backpressure passes back through both registers in the same cycle.
// Reset (rst, synchronous): both valid flags clear; payload registers are not reset.
// Depends on rtiq_pkg, rtiq_quad_if, rtiq_yuv_if, rtiq_luma and rtiq_chroma.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_i420_quad_converter import rtiq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rtiq_quad_if.sink   quad,
  rtiq_yuv_if.source  yuv
);

  quad_t quad_reg;
  logic  quad_valid;
  yuv_t  yuv_reg;
  yuv_t  yuv_next;
  logic  yuv_valid;
  logic  out_load;
  logic  in_load;

  // Stage enables: a stage loads when empty or when its content moves on
  assign out_load   = !yuv_valid || yuv.ready;
  assign in_load    = !quad_valid || out_load;
  assign quad.ready = in_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
    end else if (in_load) begin
      quad_valid <= quad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && quad.valid) begin
      quad_reg <= quad.data;
    end
  end

  // Conversion datapath
  rtiq_luma u_luma_0 (
    .red(quad_reg.red_0), .green(quad_reg.green_0), .blue(quad_reg.blue_0),
    .luma(yuv_next.luma_0)
  );
  rtiq_luma u_luma_1 (
    .red(quad_reg.red_1), .green(quad_reg.green_1), .blue(quad_reg.blue_1),
    .luma(yuv_next.luma_1)
  );
  rtiq_luma u_luma_2 (
    .red(quad_reg.red_2), .green(quad_reg.green_2), .blue(quad_reg.blue_2),
    .luma(yuv_next.luma_2)
  );
  rtiq_luma u_luma_3 (
    .red(quad_reg.red_3), .green(quad_reg.green_3), .blue(quad_reg.blue_3),
    .luma(yuv_next.luma_3)
  );
  rtiq_chroma u_chroma (
    .quad(quad_reg),
    .chroma_blue(yuv_next.chroma_blue),
    .chroma_red(yuv_next.chroma_red)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      yuv_valid <= 1'b0;
    end else if (out_load) begin
      yuv_valid <= quad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && quad_valid) begin
      yuv_reg <= yuv_next;
    end
  end

  assign yuv.valid = yuv_valid;
  assign yuv.data  = yuv_reg;

endmodule

`default_nettype wire

### hw/rtl/rtiq_luma.sv
// Luma of one RGB pixel: weighted sum, rounding, offset and clamp.
// Depends on rtiq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtiq_luma import rtiq_pkg::*; (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] luma
);

  logic [16:0] sum;
  logic [9:0]  offset_val;

  // Weighted sum with half-LSB rounding; peaks below 2^16
  assign sum = 17'(LUMA_COEF_R) * 17'(red) + 17'(LUMA_COEF_G) * 17'(green)
             + 17'(LUMA_COEF_B) * 17'(blue) + 17'(ROUND_HALF);

  assign offset_val = {1'b0, sum[16:8]} + 10'(LUMA_OFFSET);
  assign luma       = clamp_u8(offset_val, LUMA_MIN, LUMA_MAX);

endmodule

`default_nettype wire

### hw/rtl/rtiq_chroma.sv
// Chroma pair of one quad: per-channel averages, then Cb and Cr with floor shift.
// Depends on rtiq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtiq_chroma import rtiq_pkg::*; (
  input  quad_t      quad,
  output logic [7:0] chroma_blue,
  output logic [7:0] chroma_red
);

  logic [9:0]  red_sum, green_sum, blue_sum;
  logic [7:0]  red_avg, green_avg, blue_avg;
  logic [16:0] cb_pos, cb_neg, cr_pos, cr_neg;
  logic [16:0] cb_sum, cr_sum;

  // Four-pixel sums, floor divide by 4
  assign red_sum   = 10'(quad.red_0) + 10'(quad.red_1) + 10'(quad.red_2) + 10'(quad.red_3);
  assign green_sum = 10'(quad.green_0) + 10'(quad.green_1)
                   + 10'(quad.green_2) + 10'(quad.green_3);
  assign blue_sum  = 10'(quad.blue_0) + 10'(quad.blue_1)
                   + 10'(quad.blue_2) + 10'(quad.blue_3);
  assign red_avg   = red_sum[9:2];
  assign green_avg = green_sum[9:2];
  assign blue_avg  = blue_sum[9:2];

  // Positive and negative parts of each weighted sum
  assign cb_pos = 17'(CB_COEF_B) * 17'(blue_avg);
  assign cb_neg = 17'(CB_COEF_R) * 17'(red_avg) + 17'(CB_COEF_G) * 17'(green_avg);
  assign cr_pos = 17'(CR_COEF_R) * 17'(red_avg);
  assign cr_neg = 17'(CR_COEF_G) * 17'(green_avg) + 17'(CR_COEF_B) * 17'(blue_avg);

  // Bias of 128 << 8 keeps the total positive, so a logical shift is a floor
  // shift and already carries the +128 offset
  assign cb_sum = cb_pos + 17'(ROUND_HALF) + CHROMA_BIAS - cb_neg;
  assign cr_sum = cr_pos + 17'(ROUND_HALF) + CHROMA_BIAS - cr_neg;

  assign chroma_blue = clamp_u8({1'b0, cb_sum[16:8]}, CHROMA_MIN, CHROMA_MAX);
  assign chroma_red  = clamp_u8({1'b0, cr_sum[16:8]}, CHROMA_MIN, CHROMA_MAX);

endmodule

`default_nettype wire

### hw/rtl/rtiq_checker.sv
// Port-level checker for the RGB quad to I420 converter, bound to the top level.
// Depends on rtiq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rtiq_checker import rtiq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input yuv_t out_data
);

  logic in_fire;
  logic out_stall;
  logic luma_ok;
  logic chroma_ok;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // Field range flags
  assign luma_ok = (out_data.luma_0 >= LUMA_MIN) && (out_data.luma_0 <= LUMA_MAX)
                && (out_data.luma_1 >= LUMA_MIN) && (out_data.luma_1 <= LUMA_MAX)
                && (out_data.luma_2 >= LUMA_MIN) && (out_data.luma_2 <= LUMA_MAX)
                && (out_data.luma_3 >= LUMA_MIN) && (out_data.luma_3 <= LUMA_MAX);
  assign chroma_ok = (out_data.chroma_blue >= CHROMA_MIN)
                  && (out_data.chroma_blue <= CHROMA_MAX)
                  && (out_data.chroma_red >= CHROMA_MIN)
                  && (out_data.chroma_red <= CHROMA_MAX);

  // A stalled result stays offered
  `AST_NEXT(a_out_hold, clk, rst, out_stall, out_valid, "result dropped while stalled")

  // A stalled result keeps its value
  `AST_NEXT(a_out_stable, clk, rst, out_stall, $stable(out_data), "result changed while stalled")

  // An accepted item reaches the output through both registers when the sink takes the slot in between
  `AST_NEXT(a_latency, clk, rst, in_fire ##1 out_ready, out_valid, "item not delivered in time")

  // Results sit inside the limited ranges
  `AST_SAME(a_range, clk, rst, out_valid, luma_ok && chroma_ok, "result out of limited range")

endmodule

bind rgb_to_i420_quad_converter rtiq_checker u_rtiq_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(quad.valid),
  .in_ready(quad.ready),
  .out_valid(yuv.valid),
  .out_ready(yuv.ready),
  .out_data(yuv.data)
);

`default_nettype wire
